// ===== rtl/ibmh_pkg.sv =====
`timescale 1ns / 1ps
package ibmh_pkg;

  // operation codes
  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_ERASE  = 3'd1;
  localparam logic [2:0] FN_PEEK   = 3'd2;
  localparam logic [2:0] FN_POP    = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_NOTPRES = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // datapath micro-operations
  localparam logic [4:0] MOP_NONE        = 5'd0;
  localparam logic [4:0] MOP_WIPE        = 5'd1;
  localparam logic [4:0] MOP_ACCEPT      = 5'd2;
  localparam logic [4:0] MOP_READ_TOP    = 5'd3;
  localparam logic [4:0] MOP_INS_START   = 5'd4;
  localparam logic [4:0] MOP_ERASE_START = 5'd5;
  localparam logic [4:0] MOP_POP_START   = 5'd6;
  localparam logic [4:0] MOP_PEEK        = 5'd7;
  localparam logic [4:0] MOP_UP_RD       = 5'd8;
  localparam logic [4:0] MOP_UP_MOVE     = 5'd9;
  localparam logic [4:0] MOP_PLACE       = 5'd10;
  localparam logic [4:0] MOP_DN_RD       = 5'd11;
  localparam logic [4:0] MOP_DN_A        = 5'd12;
  localparam logic [4:0] MOP_DN_MOVE     = 5'd13;
  localparam logic [4:0] MOP_CL_INIT     = 5'd14;
  localparam logic [4:0] MOP_CL_RD       = 5'd15;
  localparam logic [4:0] MOP_CL_WR       = 5'd16;
  localparam logic [4:0] MOP_CL_END      = 5'd17;
  localparam logic [4:0] MOP_FIN         = 5'd18;

  typedef struct packed {
    logic [4:0] mop;
    logic       set_status;
    logic [2:0] status;
  } ibmh_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       bad_id;
    logic       present;
    logic       occ_zero;
    logic       occ_one;
    logic       full;
    logic       pos_lt_occ;
    logic       posv_one;
    logic       up_prec;
    logic       pos_half_gt1;
    logic       dn_has_child;
    logic       dn_move;
    logic       cl_last;
    logic       wipe_last;
    logic       out_free;
  } ibmh_stat_t;

endpackage

// ===== rtl/ibmh_ram.sv =====
`timescale 1ns / 1ps
module ibmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ibmh_ctrl.sv =====
`timescale 1ns / 1ps
module ibmh_ctrl
  import ibmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  ibmh_stat_t st,
  output logic       in_ready,
  output ibmh_cmd_t  cmd
);

  localparam logic [3:0] S_WIPE   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_UP_RD  = 4'd4;
  localparam logic [3:0] S_UP_CMP = 4'd5;
  localparam logic [3:0] S_PLACE  = 4'd6;
  localparam logic [3:0] S_DN     = 4'd7;
  localparam logic [3:0] S_DN_A   = 4'd8;
  localparam logic [3:0] S_DN_B   = 4'd9;
  localparam logic [3:0] S_CL_RD  = 4'd10;
  localparam logic [3:0] S_CL_WR  = 4'd11;
  localparam logic [3:0] S_CL_END = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       first_r, first_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd = '{mop: MOP_NONE, set_status: 1'b0, status: ST_OK};
    case (state_r)
      S_WIPE: begin
        cmd.mop = MOP_WIPE;
        if (st.wipe_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.mop = MOP_ACCEPT;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.mop = MOP_READ_TOP;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        first_nxt = 1'b0;
        case (st.func)
          FN_INSERT: begin
            if (st.bad_id) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_NOTPRES;
            end else if (st.present) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_DUP;
            end else if (st.full) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_FULL;
            end else begin
              cmd.mop = MOP_INS_START;
              state_nxt = st.occ_zero ? S_PLACE : S_UP_RD;
            end
          end
          FN_ERASE: begin
            if (st.bad_id || !st.present || st.occ_zero) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_NOTPRES;
            end else begin
              cmd.mop = MOP_ERASE_START;
              first_nxt = 1'b1;
              if (!st.pos_lt_occ) begin
                state_nxt = S_FIN;
              end else if (st.posv_one) begin
                state_nxt = S_DN;
              end else begin
                state_nxt = S_UP_RD;
              end
            end
          end
          FN_PEEK: begin
            if (st.occ_zero) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_EMPTY;
            end else begin
              cmd.mop = MOP_PEEK;
            end
          end
          FN_POP: begin
            if (st.occ_zero) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_EMPTY;
            end else begin
              cmd.mop = MOP_POP_START;
              state_nxt = st.occ_one ? S_FIN : S_DN;
            end
          end
          FN_CLEAR: begin
            if (!st.occ_zero) begin
              cmd.mop = MOP_CL_INIT;
              state_nxt = S_CL_RD;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_UP_RD: begin
        cmd.mop = MOP_UP_RD;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (st.up_prec) begin
          cmd.mop = MOP_UP_MOVE;
          first_nxt = 1'b0;
          state_nxt = st.pos_half_gt1 ? S_UP_RD : S_PLACE;
        end else if (first_r) begin
          // erased slot does not rise, push it down instead
          first_nxt = 1'b0;
          state_nxt = S_DN;
        end else begin
          cmd.mop = MOP_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_PLACE: begin
        cmd.mop = MOP_PLACE;
        state_nxt = S_FIN;
      end
      S_DN: begin
        if (st.dn_has_child) begin
          cmd.mop = MOP_DN_RD;
          state_nxt = S_DN_A;
        end else begin
          cmd.mop = MOP_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_DN_A: begin
        cmd.mop = MOP_DN_A;
        state_nxt = S_DN_B;
      end
      S_DN_B: begin
        if (st.dn_move) begin
          cmd.mop = MOP_DN_MOVE;
          state_nxt = S_DN;
        end else begin
          cmd.mop = MOP_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_CL_RD: begin
        cmd.mop = MOP_CL_RD;
        state_nxt = S_CL_WR;
      end
      S_CL_WR: begin
        cmd.mop = MOP_CL_WR;
        state_nxt = st.cl_last ? S_CL_END : S_CL_RD;
      end
      S_CL_END: begin
        cmd.mop = MOP_CL_END;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.mop = MOP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

// ===== rtl/ibmh_dp.sv =====
`timescale 1ns / 1ps
module ibmh_dp
  import ibmh_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int NUM_IDS   = 4096,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ibmh_cmd_t   cmd,
  output ibmh_stat_t  st,
  input  logic [2:0]  in_func,
  input  logic [11:0] in_item_id,
  input  logic [31:0] in_key_primary,
  input  logic [31:0] in_key_secondary,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_min_id,
  output logic [31:0] out_min_primary,
  output logic [31:0] out_min_secondary,
  output logic [10:0] out_count
);

  localparam int NIDS = (NUM_IDS < 4096) ? NUM_IDS : 4096;
  localparam int IDW  = $clog2(NIDS);
  localparam int KW   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int EW   = IDW + 2 * KW;
  localparam int HD   = CAPACITY + 1;
  localparam int SW   = $clog2(HD);

  logic [2:0]     func_r;
  logic           bad_r;
  logic [EW-1:0]  e_r, last_r, a_r;
  logic [SW-1:0]  posv_r, pos_r, c_r, occ_r;
  logic [IDW-1:0] clr_r;
  logic [2:0]     res_status_r;
  logic [IDW-1:0] res_id_r;
  logic [KW-1:0]  res_kp_r, res_ks_r;
  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [11:0]    out_min_id_r;
  logic [31:0]    out_min_primary_r, out_min_secondary_r;
  logic [10:0]    out_count_r;

  logic           heap_we;
  logic [SW-1:0]  heap_waddr, heap_raddr;
  logic [EW-1:0]  heap_wdata, heap_rdata;
  logic           pm_we;
  logic [IDW-1:0] pm_waddr, pm_raddr;
  logic [SW-1:0]  pm_wdata, pm_rdata;

  logic           use_b, pb_a, pb_e, pa_e;
  logic [EW-1:0]  child;
  logic [SW-1:0]  c_sel;
  logic [SW:0]    two_pos;
  logic [31:0]    occ_ext;

  function automatic logic prec(input logic [EW-1:0] x, input logic [EW-1:0] y);
    prec = x[2*KW-1:0] < y[2*KW-1:0];
  endfunction

  function automatic logic [IDW-1:0] id_of(input logic [EW-1:0] x);
    id_of = x[EW-1 -: IDW];
  endfunction

  ibmh_ram #(.WIDTH(EW), .DEPTH(HD)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  ibmh_ram #(.WIDTH(SW), .DEPTH(NIDS)) u_posmap (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  // child selection for sift-down, compares in parallel
  assign pb_a    = prec(heap_rdata, a_r);
  assign pb_e    = prec(heap_rdata, e_r);
  assign pa_e    = prec(a_r, e_r);
  assign use_b   = (c_r != occ_r) && pb_a;
  assign child   = use_b ? heap_rdata : a_r;
  assign c_sel   = use_b ? c_r + SW'(1) : c_r;
  assign two_pos = {pos_r, 1'b0};
  assign occ_ext = 32'(occ_r);

  always_comb begin
    st.func         = func_r;
    st.bad_id       = bad_r;
    st.present      = (posv_r != '0);
    st.occ_zero     = (occ_r == '0);
    st.occ_one      = (occ_r == SW'(1));
    st.full         = (occ_ext >= 32'(CAPACITY));
    st.pos_lt_occ   = (posv_r < occ_r);
    st.posv_one     = (posv_r == SW'(1));
    st.up_prec      = prec(e_r, heap_rdata);
    st.pos_half_gt1 = ((pos_r >> 1) > SW'(1));
    st.dn_has_child = (two_pos <= {1'b0, occ_r});
    st.dn_move      = use_b ? pb_e : pa_e;
    st.cl_last      = (pos_r == occ_r);
    st.wipe_last    = (32'(clr_r) == 32'(NIDS - 1));
    st.out_free     = !out_valid_r || out_ready;
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos_r;
    heap_wdata = e_r;
    heap_raddr = pos_r;
    pm_we      = 1'b0;
    pm_waddr   = id_of(e_r);
    pm_wdata   = pos_r;
    pm_raddr   = in_item_id[IDW-1:0];
    case (cmd.mop)
      MOP_WIPE: begin
        pm_we    = 1'b1;
        pm_waddr = clr_r;
        pm_wdata = '0;
      end
      MOP_ACCEPT:    heap_raddr = occ_r;
      MOP_READ_TOP:  heap_raddr = SW'(1);
      MOP_ERASE_START: begin
        pm_we    = 1'b1;
        pm_wdata = '0;
      end
      MOP_POP_START: begin
        pm_we    = 1'b1;
        pm_waddr = id_of(heap_rdata);
        pm_wdata = '0;
      end
      MOP_UP_RD:     heap_raddr = pos_r >> 1;
      MOP_UP_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = heap_rdata;
        pm_we      = 1'b1;
        pm_waddr   = id_of(heap_rdata);
      end
      MOP_PLACE: begin
        heap_we = 1'b1;
        pm_we   = 1'b1;
      end
      MOP_DN_RD:     heap_raddr = two_pos[SW-1:0];
      MOP_DN_A:      heap_raddr = c_r + SW'(1);
      MOP_DN_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = child;
        pm_we      = 1'b1;
        pm_waddr   = id_of(child);
      end
      MOP_CL_RD:     heap_raddr = pos_r;
      MOP_CL_WR: begin
        pm_we    = 1'b1;
        pm_waddr = id_of(heap_rdata);
        pm_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mop == MOP_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.mop)
        MOP_WIPE:        clr_r <= clr_r + IDW'(1);
        MOP_INS_START:   occ_r <= occ_r + SW'(1);
        MOP_ERASE_START: occ_r <= occ_r - SW'(1);
        MOP_POP_START:   occ_r <= occ_r - SW'(1);
        MOP_CL_END:      occ_r <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.mop)
      MOP_ACCEPT: begin
        func_r       <= in_func;
        bad_r        <= (32'(in_item_id) >= 32'(NUM_IDS));
        e_r          <= {in_item_id[IDW-1:0], in_key_primary[KW-1:0],
                         in_key_secondary[KW-1:0]};
        res_status_r <= ST_OK;
        res_id_r     <= '0;
        res_kp_r     <= '0;
        res_ks_r     <= '0;
      end
      MOP_READ_TOP: begin
        posv_r <= pm_rdata;
        last_r <= heap_rdata;
      end
      MOP_INS_START:   pos_r <= occ_r + SW'(1);
      MOP_ERASE_START: begin
        e_r   <= last_r;
        pos_r <= posv_r;
      end
      MOP_POP_START: begin
        res_id_r <= id_of(heap_rdata);
        res_kp_r <= heap_rdata[2*KW-1 -: KW];
        res_ks_r <= heap_rdata[KW-1:0];
        e_r      <= last_r;
        pos_r    <= SW'(1);
      end
      MOP_PEEK: begin
        res_id_r <= id_of(heap_rdata);
        res_kp_r <= heap_rdata[2*KW-1 -: KW];
        res_ks_r <= heap_rdata[KW-1:0];
      end
      MOP_UP_MOVE:  pos_r <= pos_r >> 1;
      MOP_DN_RD:    c_r   <= two_pos[SW-1:0];
      MOP_DN_A:     a_r   <= heap_rdata;
      MOP_DN_MOVE:  pos_r <= c_sel;
      MOP_CL_INIT:  pos_r <= SW'(1);
      MOP_CL_WR:    pos_r <= pos_r + SW'(1);
      MOP_FIN: begin
        out_status_r        <= res_status_r;
        out_min_id_r        <= 12'(res_id_r);
        out_min_primary_r   <= 32'(res_kp_r);
        out_min_secondary_r <= 32'(res_ks_r);
        out_count_r         <= occ_ext[10:0];
      end
      default: ;
    endcase
    if (cmd.set_status) begin
      res_status_r <= cmd.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_min_id        = out_min_id_r;
  assign out_min_primary   = out_min_primary_r;
  assign out_min_secondary = out_min_secondary_r;
  assign out_count         = out_count_r;

endmodule

// ===== rtl/indexed_binary_min_heap_top.sv =====
`timescale 1ns / 1ps
// indexed binary min-heap of item ids, ordered by (primary, secondary) key
// input channel in_valid/in_ready carries one operation per transfer:
//   insert, erase by id, peek min, pop min, clear (in_func)
// result channel out_valid/out_ready returns one result per operation:
//   status, min id and keys (peek/pop), item count after the operation
// each operation is sequenced around the heap ram's single read port:
//   lookup, then sift-up reads the parent and compares per level, sift-down
//   does two child reads and a move per level, then the entry is placed and
//   the output register is loaded
//   clear reads and unmaps each stored item in turn
// one operation is in flight at a time; in_ready is high only when idle
// a finished result waits in the output register, and the next operation
// is accepted meanwhile; it completes once the receiver takes the old one
// reset: a wipe pass zeroes the id-to-slot map, one id per cycle
//   (NUM_IDS ids, capped at 4096), with in_ready held low throughout
module indexed_binary_min_heap_top
  import ibmh_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int NUM_IDS   = 4096,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [11:0] in_item_id,
  input  logic [31:0] in_key_primary,
  input  logic [31:0] in_key_secondary,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_min_id,
  output logic [31:0] out_min_primary,
  output logic [31:0] out_min_secondary,
  output logic [10:0] out_count
);

  // command and status between sequencer and datapath
  ibmh_cmd_t  cmd;
  ibmh_stat_t st;

  ibmh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ibmh_dp #(
    .CAPACITY  (CAPACITY),
    .NUM_IDS   (NUM_IDS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_func           (in_func),
    .in_item_id        (in_item_id),
    .in_key_primary    (in_key_primary),
    .in_key_secondary  (in_key_secondary),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_min_id        (out_min_id),
    .out_min_primary   (out_min_primary),
    .out_min_secondary (out_min_secondary),
    .out_count         (out_count)
  );

  // the wipe pass keeps the input closed right after reset
  a_wipe_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open during map wipe");

  // occupancy never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= 32'(CAPACITY)))
    else $error("count above capacity");

  // an empty-heap answer carries no minimum
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |->
      (out_min_id == '0 && out_min_primary == '0 && out_count == '0))
    else $error("empty result with minimum fields set");

  // only peek or pop with ok status reports a nonzero id... so a rejected
  // insert or erase never shows one
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_DUP || out_status == ST_NOTPRES ||
                   out_status == ST_FULL)) |-> (out_min_id == '0))
    else $error("rejected operation reports an id");

endmodule
